// ===== rtl/ms_pkg.sv =====
// ----------------------------------------------------------------------------
// ms_pkg: shared types for the merge sorter
// Sequencer states, RAM control and output pipeline structs.
// ----------------------------------------------------------------------------
package ms_pkg;

	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_MERGE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic we0;
		logic we1;
		logic rsel;
	} ram_ctl_t;

	typedef struct packed {
		logic valid;
		logic last;
	} out_pipe_t;

endpackage

// ===== rtl/ms_ram.sv =====
// ----------------------------------------------------------------------------
// ms_ram: value bank
// One write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module ms_ram import ms_pkg::*; #(
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [AW-1:0]     raddr_a,
	input  logic [AW-1:0]     raddr_b,
	output logic [DATA_W-1:0] rdata_a,
	output logic [DATA_W-1:0] rdata_b
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/ms_seq.sv =====
// ----------------------------------------------------------------------------
// ms_seq: load and merge sequencer
// Loads beats into bank 0, runs bottom-up merge passes ping-ponging between
// the two banks with one shared compare unit, then streams the sorted set.
// ----------------------------------------------------------------------------
module ms_seq import ms_pkg::*; #(
	parameter int MAX_ITEMS = 64,
	parameter int CW        = $clog2(MAX_ITEMS + 1),
	parameter int AW        = $clog2(MAX_ITEMS)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [DATA_W-1:0] in_value,
	input  logic              in_last,
	input  logic [DATA_W-1:0] rd_a,
	input  logic [DATA_W-1:0] rd_b,
	output ram_ctl_t          ram_ctl,
	output logic [AW-1:0]     waddr,
	output logic [DATA_W-1:0] wdata,
	output logic [AW-1:0]     raddr_a,
	output logic [AW-1:0]     raddr_b,
	output out_pipe_t         out_s1
);

	state_t        state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [CW-1:0] w_q, w_d;
	logic [CW-1:0] h_q, h_d;
	logic [CW-1:0] j_q, j_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] mid_q, mid_d;
	logic [CW-1:0] hi_q, hi_d;
	logic          src_q, src_d;

	logic              accept, full;
	logic [CW-1:0]     n_after;
	logic              a_ok, b_ok, le, take_a;
	logic [DATA_W-1:0] pick;
	logic [CW-1:0]     k_inc;
	logic              run_end, pass_end, last_pass, out_end;
	logic [CW+1:0]     n_ext, sum_mid, sum_hi, sum_hp;
	logic [CW-1:0]     mid_n, hi_n, hi_p;
	logic [CW:0]       w2;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && (state_q == ST_IDLE);
	assign full   = (cnt_q == CW'(MAX_ITEMS));
	assign n_after = full ? cnt_q : cnt_q + CW'(1);

	// shared compare unit, stable on ties
	assign a_ok   = (h_q < mid_q);
	assign b_ok   = (j_q < hi_q);
	assign le     = ($signed(rd_a) <= $signed(rd_b));
	assign take_a = a_ok && (!b_ok || le);
	assign pick   = take_a ? rd_a : rd_b;

	assign k_inc    = k_q + CW'(1);
	assign run_end  = (k_inc == hi_q);
	assign pass_end = run_end && (hi_q == cnt_q);
	assign out_end  = (k_inc == cnt_q);

	assign n_ext   = {2'b00, cnt_q};
	assign sum_mid = {2'b00, hi_q} + {2'b00, w_q};
	assign sum_hi  = {2'b00, hi_q} + {1'b0, w_q, 1'b0};
	assign mid_n   = (sum_mid > n_ext) ? cnt_q : sum_mid[CW-1:0];
	assign hi_n    = (sum_hi > n_ext) ? cnt_q : sum_hi[CW-1:0];

	assign w2        = {w_q, 1'b0};
	assign last_pass = (w2 >= {1'b0, cnt_q});
	assign sum_hp    = {w2, 1'b0};
	assign hi_p      = (sum_hp > n_ext) ? cnt_q : sum_hp[CW-1:0];

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_last) begin
					state_d = (n_after == CW'(1)) ? ST_OUT : ST_PRIME;
				end
			end
			ST_PRIME: begin
				state_d = ST_MERGE;
			end
			ST_MERGE: begin
				if (pass_end) begin
					state_d = last_pass ? ST_OUT : ST_PRIME;
				end
			end
			ST_OUT: begin
				if (out_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cnt_d = cnt_q;
		w_d   = w_q;
		h_d   = h_q;
		j_d   = j_q;
		k_d   = k_q;
		mid_d = mid_q;
		hi_d  = hi_q;
		src_d = src_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cnt_d = n_after;
					if (in_last) begin
						w_d   = CW'(1);
						h_d   = '0;
						j_d   = CW'(1);
						mid_d = CW'(1);
						hi_d  = CW'(2);
						k_d   = '0;
						src_d = 1'b0;
					end
				end
			end
			ST_MERGE: begin
				if (!run_end) begin
					h_d = take_a ? h_q + CW'(1) : h_q;
					j_d = take_a ? j_q : j_q + CW'(1);
					k_d = k_inc;
				end else if (!pass_end) begin
					h_d   = hi_q;
					j_d   = mid_n;
					mid_d = mid_n;
					hi_d  = hi_n;
					k_d   = k_inc;
				end else begin
					w_d   = w2[CW-1:0];
					h_d   = '0;
					j_d   = w2[CW-1:0];
					mid_d = w2[CW-1:0];
					hi_d  = hi_p;
					k_d   = '0;
					src_d = !src_q;
				end
			end
			ST_OUT: begin
				k_d = k_inc;
				if (out_end) begin
					cnt_d = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_ctl      = '0;
		ram_ctl.rsel = src_q;
		waddr        = k_q[AW-1:0];
		wdata        = pick;
		raddr_a      = h_q[AW-1:0];
		raddr_b      = j_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				ram_ctl.we0 = accept && !full;
				waddr       = cnt_q[AW-1:0];
				wdata       = in_value;
			end
			ST_MERGE: begin
				ram_ctl.we0 = src_q;
				ram_ctl.we1 = !src_q;
				raddr_a     = h_d[AW-1:0];
				raddr_b     = j_d[AW-1:0];
			end
			ST_OUT: begin
				raddr_a = k_q[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			src_q   <= 1'b0;
			out_s1  <= '0;
		end else begin
			state_q      <= state_d;
			cnt_q        <= cnt_d;
			src_q        <= src_d;
			out_s1.valid <= (state_q == ST_OUT);
			out_s1.last  <= (state_q == ST_OUT) && out_end;
		end
	end

	always_ff @(posedge clk) begin
		w_q   <= w_d;
		h_q   <= h_d;
		j_q   <= j_d;
		k_q   <= k_d;
		mid_q <= mid_d;
		hi_q  <= hi_d;
	end

endmodule

// ===== rtl/merge_sorter.sv =====
// ----------------------------------------------------------------------------
// merge_sorter: stable bottom-up merge sorter for signed 32-bit values
// Loads one beat per cycle; a beat with in_last starts the sort of n values.
// Sorting runs ceil(log2 n) merge passes, one element per cycle within a pass
// through the shared compare unit; then n results stream out on consecutive
// cycles from the registered read path. busy is high from the last beat
// until the final result address is issued. Results cannot be stalled.
// Reset clears the count and sequencer; bank contents are not cleared.
// ----------------------------------------------------------------------------
module merge_sorter import ms_pkg::*; #(
	parameter int MAX_ITEMS = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [DATA_W-1:0] in_value,
	input  logic                     in_last,
	output logic                     valid,
	output logic signed [DATA_W-1:0] out_value,
	output logic                     out_last
);

	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = $clog2(MAX_ITEMS + 1);

	ram_ctl_t          ram_ctl;
	out_pipe_t         out_s1;
	logic [AW-1:0]     waddr, raddr_a, raddr_b;
	logic [DATA_W-1:0] wdata;
	logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
	logic [DATA_W-1:0] rd_a, rd_b;
	logic              valid_q, last_q;
	logic [DATA_W-1:0] value_q;

	assign rd_a = ram_ctl.rsel ? rd1_a : rd0_a;
	assign rd_b = ram_ctl.rsel ? rd1_b : rd0_b;

	ms_seq #(
		.MAX_ITEMS(MAX_ITEMS),
		.CW       (CW),
		.AW       (AW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.in_value(in_value),
		.in_last (in_last),
		.rd_a    (rd_a),
		.rd_b    (rd_b),
		.ram_ctl (ram_ctl),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.out_s1  (out_s1)
	);

	ms_ram #(
		.DEPTH(MAX_ITEMS),
		.AW   (AW)
	) u_bank0 (
		.clk    (clk),
		.we     (ram_ctl.we0),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd0_a),
		.rdata_b(rd0_b)
	);

	ms_ram #(
		.DEPTH(MAX_ITEMS),
		.AW   (AW)
	) u_bank1 (
		.clk    (clk),
		.we     (ram_ctl.we1),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rd1_a),
		.rdata_b(rd1_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			valid_q <= out_s1.valid;
			last_q  <= out_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		value_q <= rd_a;
	end

	assign valid     = valid_q;
	assign out_last  = last_q;
	assign out_value = value_q;

endmodule

// ===== rtl/ms_checker.sv =====
// ----------------------------------------------------------------------------
// ms_checker: port-level checks for the merge sorter
// Load/sort hand-off and result stream shape.
// ----------------------------------------------------------------------------
module ms_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic in_last,
	input logic valid,
	input logic out_last
);

	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !in_last |=> !busy)
		else $error("busy rose on a beat without last");

	a_last_starts_sort: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_last |=> busy)
		else $error("busy not raised after last beat");

	a_result_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid |-> $past(busy, 2))
		else $error("result without a preceding sort");

	a_stream_gapless: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !out_last |=> valid)
		else $error("gap in result stream");

	a_stream_ends: assert property (@(posedge clk) disable iff (!arst_n)
		valid && out_last |=> !valid)
		else $error("result after final beat");

endmodule

bind merge_sorter ms_checker u_ms_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.in_last (in_last),
	.valid   (valid),
	.out_last(out_last)
);
